### sv/sair_pkg.sv
// ----------------------------------------------------------------------------
// sair_pkg
// Shared types and constants for the shifting array with insert and remove.
// ----------------------------------------------------------------------------
package sair_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int POS_W     = 6;
    localparam int MODE_W    = 3;

    // Operation codes carried in the mode field; codes 6 and 7 are no-ops.
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SET    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_COUNT  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DUMP   = 3'd5;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] operand_value;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     last_of_run;
    } t_out;

    // Per-cycle command broadcast along the cell chain.
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE,
        OP_SET,
        OP_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op                 op;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COUNT,
        ST_DUMP
    } t_state;

endpackage

### sv/shifting_array_insert_remove.sv
// ----------------------------------------------------------------------------
// shifting_array_insert_remove
// Array of DEPTH signed words held in a chain of cells, with insert (shift
// up), remove (shift down), set, read, count-equal and dump operations.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in_data  (sair_pkg::t_in)
//  out     | output    | o_out_valid / i_out_ready | o_out_data (sair_pkg::t_out)
//
// Insert, remove and set: every cell updates in parallel.
// Read: result lands in the output register.
// Count: compare per cell, then a registered population count.
// Dump: the chain rotates down by one place per emitted entry, so after DEPTH
//   steps the contents are back in place. Stalls on the output pause the
//   rotation.
// Reset (synchronous, active low) clears every entry to zero; no clearing pass.
// A transaction with no result is taken whenever the block is idle and the
// output register is empty or draining.
//
module shifting_array_insert_remove #(
    parameter int DEPTH = sair_pkg::DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  sair_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output sair_pkg::t_out  o_out_data
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [sair_pkg::POS_W:0] DEPTH_CMP = (sair_pkg::POS_W + 1)'(DEPTH);

    // Cell chain wiring
    logic signed [sair_pkg::DATA_W-1:0] w_entry [DEPTH];
    logic [DEPTH-1:0]                   w_match;
    sair_pkg::t_cell_ctrl               w_ctrl;

    // Control state
    sair_pkg::t_state r_state;
    sair_pkg::t_state n_state;
    logic [IDX_W-1:0] r_cnt;
    logic [IDX_W-1:0] n_cnt;
    logic [DEPTH-1:0] r_match;
    logic [DEPTH-1:0] n_match;

    // Output register
    logic           r_out_valid;
    logic           n_out_valid;
    sair_pkg::t_out r_out_data;
    sair_pkg::t_out n_out_data;

    logic w_slot_free;
    logic w_accept;
    logic w_inside;

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++) begin : g_cell
            logic signed [sair_pkg::DATA_W-1:0] w_left;
            logic signed [sair_pkg::DATA_W-1:0] w_right;

            if (k == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_entry[k-1];
            end

            // Top cell: zero fill on remove, wraps entry 0 in on rotate.
            if (k == DEPTH - 1) begin : g_top
                assign w_right = (w_ctrl.op == sair_pkg::OP_ROTATE) ? w_entry[0] : '0;
            end else begin : g_mid_r
                assign w_right = w_entry[k+1];
            end

            sair_cell #(
                .IDX(k)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_left  (w_left),
                .i_right (w_right),
                .o_entry (w_entry[k]),
                .o_match (w_match[k])
            );
        end
    endgenerate

    // Output register can take a new result this cycle
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == sair_pkg::ST_IDLE) && w_slot_free;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_inside    = ({1'b0, i_in_data.position} < DEPTH_CMP);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sair_pkg::ST_IDLE: begin
                if (w_accept && i_in_data.mode == sair_pkg::MODE_COUNT) begin
                    n_state = sair_pkg::ST_COUNT;
                end else if (w_accept && i_in_data.mode == sair_pkg::MODE_DUMP) begin
                    n_state = sair_pkg::ST_DUMP;
                end
            end
            sair_pkg::ST_COUNT: begin
                if (w_slot_free) begin
                    n_state = sair_pkg::ST_IDLE;
                end
            end
            sair_pkg::ST_DUMP: begin
                if (w_slot_free && r_cnt == LAST_IDX) begin
                    n_state = sair_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sair_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath control and output register loading
    always_comb begin
        w_ctrl.op   = sair_pkg::OP_HOLD;
        w_ctrl.pos  = i_in_data.position;
        w_ctrl.val  = i_in_data.operand_value;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        n_cnt       = r_cnt;
        n_match     = r_match;

        unique case (r_state)
            sair_pkg::ST_IDLE: begin
                n_cnt = '0;
                if (w_accept) begin
                    unique case (i_in_data.mode)
                        sair_pkg::MODE_READ: begin
                            n_out_valid = 1'b1;
                            n_out_data.result_value =
                                w_inside ? w_entry[i_in_data.position[IDX_W-1:0]] : '0;
                            n_out_data.last_of_run = 1'b1;
                        end
                        sair_pkg::MODE_INSERT: begin
                            if (w_inside) begin
                                w_ctrl.op = sair_pkg::OP_INSERT;
                            end
                        end
                        sair_pkg::MODE_REMOVE: begin
                            if (w_inside) begin
                                w_ctrl.op = sair_pkg::OP_REMOVE;
                            end
                        end
                        sair_pkg::MODE_SET: begin
                            if (w_inside) begin
                                w_ctrl.op = sair_pkg::OP_SET;
                            end
                        end
                        sair_pkg::MODE_COUNT: begin
                            n_match = w_match;
                        end
                        default: begin
                            // dump starts next cycle; unused codes do nothing
                            w_ctrl.op = sair_pkg::OP_HOLD;
                        end
                    endcase
                end
            end
            sair_pkg::ST_COUNT: begin
                if (w_slot_free) begin
                    n_out_valid             = 1'b1;
                    n_out_data.result_value = sair_pkg::DATA_W'($countones(r_match));
                    n_out_data.last_of_run  = 1'b1;
                end
            end
            sair_pkg::ST_DUMP: begin
                if (w_slot_free) begin
                    // entry 0 goes out, chain rotates so the next one is at 0
                    n_out_valid             = 1'b1;
                    n_out_data.result_value = w_entry[0];
                    n_out_data.last_of_run  = (r_cnt == LAST_IDX);
                    w_ctrl.op               = sair_pkg::OP_ROTATE;
                    n_cnt                   = r_cnt + 1'b1;
                end
            end
            default: begin
                n_out_valid = r_out_valid && !i_out_ready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sair_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_match    <= n_match;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### sv/sair_cell.sv
// ----------------------------------------------------------------------------
// sair_cell
// One storage cell of the chain: holds one entry, shifts from a neighbor,
// takes a written value, and compares against the broadcast value.
// ----------------------------------------------------------------------------
module sair_cell #(
    parameter int IDX = 0
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sair_pkg::t_cell_ctrl               i_ctrl,
    input  logic signed [sair_pkg::DATA_W-1:0] i_left,
    input  logic signed [sair_pkg::DATA_W-1:0] i_right,
    output logic signed [sair_pkg::DATA_W-1:0] o_entry,
    output logic                               o_match
);

    localparam logic [sair_pkg::POS_W:0] SELF = (sair_pkg::POS_W + 1)'(IDX);

    logic signed [sair_pkg::DATA_W-1:0] r_entry;
    logic signed [sair_pkg::DATA_W-1:0] n_entry;
    logic [sair_pkg::POS_W:0]           w_pos;

    assign w_pos = {1'b0, i_ctrl.pos};

    always_comb begin
        n_entry = r_entry;
        unique case (i_ctrl.op)
            sair_pkg::OP_INSERT: begin
                if (SELF > w_pos) begin
                    n_entry = i_left;
                end else if (SELF == w_pos) begin
                    n_entry = i_ctrl.val;
                end
            end
            sair_pkg::OP_REMOVE: begin
                if (SELF >= w_pos) begin
                    n_entry = i_right;
                end
            end
            sair_pkg::OP_SET: begin
                if (SELF == w_pos) begin
                    n_entry = i_ctrl.val;
                end
            end
            sair_pkg::OP_ROTATE: begin
                n_entry = i_right;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_match = (r_entry == i_ctrl.val);

endmodule
